[rtl/core/udbs_pkg.sv]
// Shared types, constants and helper functions of the draw batch scheduler.
package udbs_pkg;

  localparam int FIGURE_SLOTS = 32;
  localparam int TEXT_SLOTS   = 16;
  localparam int MAX_BATCH    = 7;

  // slot counts hold 0..SLOTS, slot indexes 0..SLOTS-1
  localparam int FIG_CNT_W = $clog2(FIGURE_SLOTS + 1);
  localparam int TXT_CNT_W = $clog2(TEXT_SLOTS + 1);
  localparam int FIG_IDX_W = (FIGURE_SLOTS > 1) ? $clog2(FIGURE_SLOTS) : 1;
  localparam int TXT_IDX_W = (TEXT_SLOTS > 1) ? $clog2(TEXT_SLOTS) : 1;

  // field widths
  localparam int CMD_W      = 3;
  localparam int TIME_W     = 32;
  localparam int ITYPE_W    = 2;
  localparam int UOP_W      = 4;
  localparam int ENTRY_W    = 8;
  localparam int KIND_W     = 3;
  localparam int FIRST_W    = 5;
  localparam int COUNT_W    = 3;
  localparam int OPS_W      = 14;
  localparam int FIG_REG_W  = 6;
  localparam int TXT_REG_W  = 5;
  localparam int INTV_W     = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // stream word widths
  localparam int S_DATA_W = 48;
  localparam int S_USER_W = CMD_W;
  localparam int M_DATA_W = 24;
  localparam int M_USER_W = 1 + KIND_W;

  // commands
  localparam logic [CMD_W-1:0] CMD_REQUEST    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CONFIRM    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UI_OP      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ATTACH_FIG = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ATTACH_TXT = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIGURE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_INTERVAL = 2'd2;

  // interaction type that produces packets
  localparam logic [ITYPE_W-1:0] ITYPE_CLIENT_PLOT = 2'd0;

  // per-slot draw operations
  localparam logic [1:0] OP_NOP    = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;
  localparam logic [1:0] OP_DELETE = 2'd3;

  // packet kinds
  localparam logic [KIND_W-1:0] KIND_TEXT  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ONE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TWO   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FIVE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SEVEN = 3'd4;

  // ui operation codes
  localparam logic [UOP_W-1:0] UOP_LAST = 4'd14;
  localparam logic [UOP_W-1:0] UOP_HIDE_BASE = 4'd5;
  localparam logic [UOP_W-1:0] UOP_SHOW_BASE = 4'd10;

  typedef enum logic [1:0] {ACT_RESET, ACT_HIDE, ACT_SHOW} action_t;
  typedef enum logic [2:0] {SC_ALL, SC_FIGURES, SC_TEXTS, SC_FIGURE, SC_TEXT} scope_t;

  typedef struct packed {
    logic    valid;
    action_t action;
    scope_t  scope;
  } uop_dec_t;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [TIME_W-1:0]  now_time;
    logic [ITYPE_W-1:0] interaction_type;
    logic [UOP_W-1:0]   ui_operation;
    logic [ENTRY_W-1:0] entry_index;
  } item_t;

  typedef struct packed {
    logic               packet_valid;
    logic [KIND_W-1:0]  packet_kind;
    logic [FIRST_W-1:0] first_index;
    logic [COUNT_W-1:0] entry_count;
    logic [OPS_W-1:0]   entry_operations;
  } result_t;

  typedef struct packed {
    logic load_item;
    logic execute;
    logic load_result;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_request;
    logic result_free;
  } dp_status_t;

  typedef struct packed {
    logic       drawn;
    logic [1:0] op;
  } slot_res_t;

  // split a ui operation code into action and scope
  function automatic uop_dec_t decode_uop(logic [UOP_W-1:0] uop);
    uop_dec_t d;
    d.valid  = (uop <= UOP_LAST);
    d.action = ACT_RESET;
    d.scope  = SC_ALL;
    if (uop < UOP_HIDE_BASE) begin
      d.scope = scope_t'(3'(uop));
    end else if (uop < UOP_SHOW_BASE) begin
      d.action = ACT_HIDE;
      d.scope  = scope_t'(3'(uop - UOP_HIDE_BASE));
    end else begin
      d.action = ACT_SHOW;
      d.scope  = scope_t'(3'(uop - UOP_SHOW_BASE));
    end
    return d;
  endfunction

  // draw operation for one slot and its new drawn flag
  function automatic slot_res_t slot_op(logic attached, logic hidden, logic drawn);
    slot_res_t r;
    r.drawn = drawn;
    r.op    = OP_NOP;
    if (attached) begin
      if (hidden) begin
        if (drawn) begin
          r.drawn = 1'b0;
          r.op    = OP_DELETE;
        end
      end else if (drawn) begin
        r.op = OP_MODIFY;
      end else begin
        r.drawn = 1'b1;
        r.op    = OP_ADD;
      end
    end
    return r;
  endfunction

endpackage

[rtl/core/udbs_ctrl.sv]
// Controller: sequences word intake, execution and result hand-off.
module udbs_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  udbs_pkg::dp_status_t   status,
  output udbs_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid) state <= ST_EXEC;
        end
        ST_EXEC: begin
          // a request waits until the result register can take its packet
          if (!status.is_request || status.result_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    s_tready        = (state == ST_IDLE);
    cmd.load_item   = s_tvalid && s_tready;
    cmd.execute     = (state == ST_EXEC) && (!status.is_request || status.result_free);
    cmd.load_result = cmd.execute && status.is_request;
  end

endmodule

[rtl/core/udbs_dp.sv]
// Datapath: configuration, slot flag vectors, batch selection and result register.
module udbs_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  udbs_pkg::ctrl_cmd_t                  cmd,
  output udbs_pkg::dp_status_t                 status,
  input  logic [udbs_pkg::S_DATA_W-1:0]        s_tdata,
  input  logic [udbs_pkg::S_USER_W-1:0]        s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [udbs_pkg::M_DATA_W-1:0]        m_tdata,
  output logic [udbs_pkg::M_USER_W-1:0]        m_tuser,
  input  logic                                 cfg_we,
  input  logic [udbs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [udbs_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  // configuration
  logic [udbs_pkg::FIG_REG_W-1:0] figure_count;
  logic [udbs_pkg::TXT_REG_W-1:0] text_count;
  logic [udbs_pkg::INTV_W-1:0]    send_interval;

  // slot state
  logic [udbs_pkg::FIGURE_SLOTS-1:0] figure_hidden, figure_hidden_next;
  logic [udbs_pkg::FIGURE_SLOTS-1:0] figure_drawn, figure_drawn_next;
  logic [udbs_pkg::FIGURE_SLOTS-1:0] figure_attached, figure_attached_next;
  logic [udbs_pkg::TEXT_SLOTS-1:0]   text_hidden, text_hidden_next;
  logic [udbs_pkg::TEXT_SLOTS-1:0]   text_drawn, text_drawn_next;
  logic [udbs_pkg::TEXT_SLOTS-1:0]   text_attached, text_attached_next;
  logic [udbs_pkg::FIG_IDX_W-1:0]    next_figure, next_figure_next;
  logic [udbs_pkg::TXT_CNT_W-1:0]    texts_sent, texts_sent_next;
  logic [udbs_pkg::TIME_W-1:0]       last_send_time, last_send_time_next;

  udbs_pkg::item_t   item;
  udbs_pkg::result_t result, result_next;
  logic              result_full;

  // effective counts and decoded operation
  logic [udbs_pkg::FIG_CNT_W-1:0]   nf;
  logic [udbs_pkg::TXT_CNT_W-1:0]   nt;
  udbs_pkg::uop_dec_t               dec;
  logic [udbs_pkg::FIGURE_SLOTS-1:0] fig_sel;
  logic [udbs_pkg::TEXT_SLOTS-1:0]   txt_sel;
  logic [udbs_pkg::TIME_W-1:0]      elapsed;
  logic                             send_ok;
  logic [udbs_pkg::FIG_CNT_W-1:0]   start;
  logic [udbs_pkg::FIG_CNT_W-1:0]   left;
  logic [udbs_pkg::COUNT_W-1:0]     count;
  logic [udbs_pkg::KIND_W-1:0]      kind;
  logic [udbs_pkg::FIG_CNT_W:0]     end_pos;

  always_comb begin
    nf = (int'(figure_count) > udbs_pkg::FIGURE_SLOTS) ?
         udbs_pkg::FIG_CNT_W'(udbs_pkg::FIGURE_SLOTS) : udbs_pkg::FIG_CNT_W'(figure_count);
    nt = (int'(text_count) > udbs_pkg::TEXT_SLOTS) ?
         udbs_pkg::TXT_CNT_W'(udbs_pkg::TEXT_SLOTS) : udbs_pkg::TXT_CNT_W'(text_count);
    dec = udbs_pkg::decode_uop(item.ui_operation);
    for (int i = 0; i < udbs_pkg::FIGURE_SLOTS; i++) begin
      fig_sel[i] = dec.valid && (udbs_pkg::FIG_CNT_W'(i) < nf) &&
                   (dec.scope == udbs_pkg::SC_ALL || dec.scope == udbs_pkg::SC_FIGURES ||
                    (dec.scope == udbs_pkg::SC_FIGURE &&
                     item.entry_index == udbs_pkg::ENTRY_W'(i)));
    end
    for (int i = 0; i < udbs_pkg::TEXT_SLOTS; i++) begin
      txt_sel[i] = dec.valid && (udbs_pkg::TXT_CNT_W'(i) < nt) &&
                   (dec.scope == udbs_pkg::SC_ALL || dec.scope == udbs_pkg::SC_TEXTS ||
                    (dec.scope == udbs_pkg::SC_TEXT &&
                     item.entry_index == udbs_pkg::ENTRY_W'(i)));
    end
    elapsed = item.now_time - last_send_time;
    send_ok = (elapsed > udbs_pkg::TIME_W'(send_interval)) &&
              (item.interaction_type == udbs_pkg::ITYPE_CLIENT_PLOT);

    // round-robin figure batch
    start = (udbs_pkg::FIG_CNT_W'(next_figure) < nf) ?
            udbs_pkg::FIG_CNT_W'(next_figure) : '0;
    left  = nf - start;
    if (int'(left) >= udbs_pkg::MAX_BATCH) begin
      count = udbs_pkg::COUNT_W'(udbs_pkg::MAX_BATCH);
      kind  = udbs_pkg::KIND_SEVEN;
    end else if (int'(left) >= 5) begin
      count = 3'd5;
      kind  = udbs_pkg::KIND_FIVE;
    end else if (int'(left) >= 2) begin
      count = 3'd2;
      kind  = udbs_pkg::KIND_TWO;
    end else begin
      count = 3'd1;
      kind  = udbs_pkg::KIND_ONE;
    end
    end_pos = {1'b0, start} + (udbs_pkg::FIG_CNT_W + 1)'(count);
  end

  always_comb begin
    logic [udbs_pkg::FIG_CNT_W-1:0] s;
    logic [udbs_pkg::TXT_IDX_W-1:0] t;
    udbs_pkg::slot_res_t            r;
    figure_hidden_next   = figure_hidden;
    figure_drawn_next    = figure_drawn;
    figure_attached_next = figure_attached;
    text_hidden_next     = text_hidden;
    text_drawn_next      = text_drawn;
    text_attached_next   = text_attached;
    next_figure_next     = next_figure;
    texts_sent_next      = texts_sent;
    last_send_time_next  = last_send_time;
    result_next          = '0;
    s = '0;
    t = texts_sent[udbs_pkg::TXT_IDX_W-1:0];
    r = '0;
    case (item.command)
      udbs_pkg::CMD_REQUEST: begin
        if (send_ok) begin
          if (texts_sent < nt) begin
            // each text slot goes out once, one per packet
            r = udbs_pkg::slot_op(text_attached[t], text_hidden[t], text_drawn[t]);
            text_drawn_next[t]           = r.drawn;
            texts_sent_next              = texts_sent + 1'b1;
            result_next.packet_valid     = 1'b1;
            result_next.packet_kind      = udbs_pkg::KIND_TEXT;
            result_next.first_index      = udbs_pkg::FIRST_W'(texts_sent);
            result_next.entry_count      = 3'd1;
            result_next.entry_operations = udbs_pkg::OPS_W'(r.op);
          end else if (nf != '0) begin
            for (int i = 0; i < udbs_pkg::MAX_BATCH; i++) begin
              s = start + udbs_pkg::FIG_CNT_W'(i);
              if (udbs_pkg::COUNT_W'(i) < count) begin
                r = udbs_pkg::slot_op(figure_attached[s[udbs_pkg::FIG_IDX_W-1:0]],
                                      figure_hidden[s[udbs_pkg::FIG_IDX_W-1:0]],
                                      figure_drawn[s[udbs_pkg::FIG_IDX_W-1:0]]);
                figure_drawn_next[s[udbs_pkg::FIG_IDX_W-1:0]] = r.drawn;
                result_next.entry_operations[2*i +: 2]       = r.op;
              end
            end
            next_figure_next = (end_pos >= {1'b0, nf}) ?
                               '0 : end_pos[udbs_pkg::FIG_IDX_W-1:0];
            result_next.packet_valid = 1'b1;
            result_next.packet_kind  = kind;
            result_next.first_index  = udbs_pkg::FIRST_W'(start);
            result_next.entry_count  = count;
          end
        end
      end
      udbs_pkg::CMD_CONFIRM: begin
        last_send_time_next = item.now_time;
      end
      udbs_pkg::CMD_UI_OP: begin
        for (int i = 0; i < udbs_pkg::FIGURE_SLOTS; i++) begin
          if (fig_sel[i]) begin
            if (dec.action == udbs_pkg::ACT_RESET) figure_drawn_next[i] = 1'b0;
            else figure_hidden_next[i] = (dec.action == udbs_pkg::ACT_HIDE);
          end
        end
        for (int i = 0; i < udbs_pkg::TEXT_SLOTS; i++) begin
          if (txt_sel[i]) begin
            if (dec.action == udbs_pkg::ACT_RESET) text_drawn_next[i] = 1'b0;
            else text_hidden_next[i] = (dec.action == udbs_pkg::ACT_HIDE);
          end
        end
      end
      udbs_pkg::CMD_ATTACH_FIG: begin
        for (int i = 0; i < udbs_pkg::FIGURE_SLOTS; i++) begin
          if (item.entry_index == udbs_pkg::ENTRY_W'(i) && udbs_pkg::FIG_CNT_W'(i) < nf)
            figure_attached_next[i] = 1'b1;
        end
      end
      udbs_pkg::CMD_ATTACH_TXT: begin
        for (int i = 0; i < udbs_pkg::TEXT_SLOTS; i++) begin
          if (item.entry_index == udbs_pkg::ENTRY_W'(i) && udbs_pkg::TXT_CNT_W'(i) < nt)
            text_attached_next[i] = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // input word register
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item.command          <= s_tuser;
      item.now_time         <= s_tdata[31:0];
      item.interaction_type <= s_tdata[33:32];
      item.ui_operation     <= s_tdata[37:34];
      item.entry_index      <= s_tdata[45:38];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      figure_count    <= '0;
      text_count      <= '0;
      send_interval   <= '0;
      figure_hidden   <= '0;
      figure_drawn    <= '0;
      figure_attached <= '0;
      text_hidden     <= '0;
      text_drawn      <= '0;
      text_attached   <= '0;
      next_figure     <= '0;
      texts_sent      <= '0;
      last_send_time  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          udbs_pkg::CFG_FIGURE_COUNT:  figure_count  <= cfg_wdata[udbs_pkg::FIG_REG_W-1:0];
          udbs_pkg::CFG_TEXT_COUNT:    text_count    <= cfg_wdata[udbs_pkg::TXT_REG_W-1:0];
          udbs_pkg::CFG_SEND_INTERVAL: send_interval <= cfg_wdata[udbs_pkg::INTV_W-1:0];
          default: ;
        endcase
      end
      if (cmd.execute) begin
        figure_hidden   <= figure_hidden_next;
        figure_drawn    <= figure_drawn_next;
        figure_attached <= figure_attached_next;
        text_hidden     <= text_hidden_next;
        text_drawn      <= text_drawn_next;
        text_attached   <= text_attached_next;
        next_figure     <= next_figure_next;
        texts_sent      <= texts_sent_next;
        last_send_time  <= last_send_time_next;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_full <= 1'b0;
    end else if (cmd.load_result) begin
      result_full <= 1'b1;
    end else if (m_tready) begin
      result_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) result <= result_next;
  end

  assign status.is_request  = (item.command == udbs_pkg::CMD_REQUEST);
  assign status.result_free = !result_full || m_tready;

  assign m_tvalid = result_full;
  assign m_tdata  = {2'b00, result.entry_operations, result.entry_count, result.first_index};
  assign m_tuser  = {result.packet_kind, result.packet_valid};

endmodule

[rtl/core/ui_draw_batch_scheduler.sv]
// Top level of the draw batch scheduler: controller plus datapath.
//
// Input words arrive on s_* (command in s_tuser, operands in s_tdata). Every
// request word (command 0) yields exactly one output word on m_*; all other
// commands update internal state only and yield nothing.
// Configuration (figure_count, text_count, send_interval) is written through
// cfg_we / cfg_index / cfg_wdata, one register per cycle; the user must write
// it only while idle, as the block itself does not enforce this. A word is
// taken in the idle state and executed in the execute state that follows;
// the next word is taken once the controller's two-step sequence returns to
// idle. All flag updates, the batch selection and a request's result (which
// raises m_tvalid) are registered together at the end of the execute step.
// The output register holds one word; intake continues while it waits.
// A request that finds the output register still full (receiver stalled)
// waits in the execute step until m_tready frees it.
// Reset (rst, synchronous) clears all flags, pointers, the last send time,
// the configuration registers, and empties the output register.
module ui_draw_batch_scheduler (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [31:0] now_time, [33:32] interaction_type, [37:34] ui_operation,
  // [45:38] entry_index, [47:46] zero
  input  logic [udbs_pkg::S_DATA_W-1:0]      s_tdata,
  // [2:0] command
  input  logic [udbs_pkg::S_USER_W-1:0]      s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [4:0] first_index, [7:5] entry_count, [21:8] entry_operations, [23:22] zero
  output logic [udbs_pkg::M_DATA_W-1:0]      m_tdata,
  // [0] packet_valid, [3:1] packet_kind
  output logic [udbs_pkg::M_USER_W-1:0]      m_tuser,
  input  logic                               cfg_we,
  input  logic [udbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [udbs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  udbs_pkg::ctrl_cmd_t  cmd;
  udbs_pkg::dp_status_t status;

  udbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  udbs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule

[rtl/core/udbs_check.sv]
// Port-level assertions for the draw batch scheduler, bound to the top level.
module udbs_check (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [udbs_pkg::M_DATA_W-1:0]      m_tdata,
  input logic [udbs_pkg::M_USER_W-1:0]      m_tuser
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  // one word at a time: intake closes during the execute state
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken during execute");

  // empty result carries all-zero fields
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0 && m_tuser[3:1] == '0)
    else $error("empty result with nonzero fields");

  // packet kind and entry count agree
  a_kind_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |->
      (m_tuser[3:1] == udbs_pkg::KIND_TEXT  && m_tdata[7:5] == 3'd1) ||
      (m_tuser[3:1] == udbs_pkg::KIND_ONE   && m_tdata[7:5] == 3'd1) ||
      (m_tuser[3:1] == udbs_pkg::KIND_TWO   && m_tdata[7:5] == 3'd2) ||
      (m_tuser[3:1] == udbs_pkg::KIND_FIVE  && m_tdata[7:5] == 3'd5) ||
      (m_tuser[3:1] == udbs_pkg::KIND_SEVEN && m_tdata[7:5] == 3'd7))
    else $error("packet kind does not match entry count");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind ui_draw_batch_scheduler udbs_check u_check (.*);
